// ----- design/ralu_pkg.sv -----
// Package with shared types and constants for the rational ALU.
`timescale 1ns / 1ps
package ralu_pkg;

   // Operation codes carried in the kind field.
   localparam logic [2:0] OP_MAKE = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_CMP  = 3'd5;

   // Order codes of the compare result.
   localparam logic [1:0] ORD_EQ = 2'b00;
   localparam logic [1:0] ORD_GT = 2'b01;
   localparam logic [1:0] ORD_LT = 2'b11;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_PREP,
      ST_GCD,
      ST_DIVN,
      ST_DIVD,
      ST_FIN,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul_step;
      logic [1:0] mul_sel;
      logic prep;
      logic div_start;
      logic [1:0] div_mode;
      logic finish;
   } cmd_type;

   // Division modes of the shared divider.
   localparam logic [1:0] DM_GCD = 2'd0;
   localparam logic [1:0] DM_NUM = 2'd1;
   localparam logic [1:0] DM_DEN = 2'd2;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic direct;
      logic mul_done;
      logic div_done;
      logic gcd_done;
   } stat_type;

endpackage

// ----- design/ralu_if.sv -----
// Valid/ready channel interface for the rational ALU.
`timescale 1ns / 1ps
interface ralu_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- design/ralu_ctrl.sv -----
// Controller state machine of the rational ALU.
`timescale 1ns / 1ps
module ralu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   input  ralu_pkg::stat_type  stat,
   output ralu_pkg::cmd_type   cmd
);

   ralu_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ralu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state. Each cross product stays in its state until the multiplier is done.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ralu_pkg::ST_IDLE: if (in_valid) state_in = ralu_pkg::ST_MUL0;
         ralu_pkg::ST_MUL0: if (stat.mul_done) state_in = ralu_pkg::ST_MUL1;
         ralu_pkg::ST_MUL1: if (stat.mul_done) state_in = ralu_pkg::ST_MUL2;
         ralu_pkg::ST_MUL2: if (stat.mul_done) state_in = ralu_pkg::ST_MUL3;
         ralu_pkg::ST_MUL3: if (stat.mul_done) state_in = ralu_pkg::ST_PREP;
         ralu_pkg::ST_PREP: begin
            if (stat.direct) state_in = ralu_pkg::ST_OUT;
            else state_in = ralu_pkg::ST_GCD;
         end
         ralu_pkg::ST_GCD: if (stat.gcd_done) state_in = ralu_pkg::ST_DIVN;
         ralu_pkg::ST_DIVN: if (stat.div_done) state_in = ralu_pkg::ST_DIVD;
         ralu_pkg::ST_DIVD: if (stat.div_done) state_in = ralu_pkg::ST_FIN;
         ralu_pkg::ST_FIN: state_in = ralu_pkg::ST_OUT;
         ralu_pkg::ST_OUT: if (out_ready) state_in = ralu_pkg::ST_IDLE;
         default: state_in = ralu_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         ralu_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ralu_pkg::ST_MUL0: begin cmd.mul_step = 1'b1; cmd.mul_sel = 2'd0; end
         ralu_pkg::ST_MUL1: begin cmd.mul_step = 1'b1; cmd.mul_sel = 2'd1; end
         ralu_pkg::ST_MUL2: begin cmd.mul_step = 1'b1; cmd.mul_sel = 2'd2; end
         ralu_pkg::ST_MUL3: begin cmd.mul_step = 1'b1; cmd.mul_sel = 2'd3; end
         ralu_pkg::ST_PREP: cmd.prep = 1'b1;
         ralu_pkg::ST_GCD: begin
            cmd.div_mode = ralu_pkg::DM_GCD;
            cmd.div_start = stat.gcd_done;
            if (stat.gcd_done) cmd.div_mode = ralu_pkg::DM_NUM;
         end
         // The numerator quotient lands here; the denominator division starts after it.
         ralu_pkg::ST_DIVN: begin
            cmd.div_mode = ralu_pkg::DM_NUM;
            cmd.div_start = stat.div_done;
            if (stat.div_done) cmd.div_mode = ralu_pkg::DM_DEN;
         end
         ralu_pkg::ST_DIVD: cmd.div_mode = ralu_pkg::DM_DEN;
         ralu_pkg::ST_FIN: cmd.finish = 1'b1;
         ralu_pkg::ST_OUT: out_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

// ----- design/ralu_dpath.sv -----
// Datapath of the rational ALU: cross products, gcd and exact division.
`timescale 1ns / 1ps
module ralu_dpath #(
   parameter int WIDTH = 64
) (
   input  logic               clock,
   input  logic [2:0]         kind,
   input  logic [63:0]        a_num,
   input  logic [63:0]        a_den,
   input  logic [63:0]        b_num,
   input  logic [63:0]        b_den,
   input  ralu_pkg::cmd_type  cmd,
   output ralu_pkg::stat_type stat,
   output logic [63:0]        res_num,
   output logic [63:0]        res_den,
   output logic [1:0]         order
);

   localparam int CW = $clog2(WIDTH + 1);
   localparam int HW = (WIDTH + 1) / 2;
   localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

   // Operand registers.
   logic [2:0]       kind_ff;
   logic [WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   // Cross products (wrapped).
   logic [WIDTH-1:0] p_ff [4];
   // Multiplier phase and partial sum.
   logic [1:0]       mph_ff;
   logic [WIDTH-1:0] macc_ff;
   // Fraction being reduced, signed parts.
   logic [WIDTH-1:0] n_ff, d_ff, mn_ff, md_ff;
   logic [WIDTH-1:0] rn_ff, rd_ff;
   logic [1:0]       ord_ff;
   // Euclid operands.
   logic [WIDTH-1:0] gx_ff, gy_ff;
   // Shared restoring divider.
   logic [WIDTH-1:0] dq_ff, drem_ff, ddiv_ff;
   logic [CW-1:0]    dcnt_ff;
   logic             dbusy_ff, gdiv_ff;

   function automatic logic [WIDTH-1:0] wneg(input logic [WIDTH-1:0] x);
      wneg = WIDTH'(0) - x;
   endfunction

   function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] x);
      mag = x[WIDTH-1] ? wneg(x) : x;
   endfunction

   // Operand pair of each of the four cross products.
   logic [WIDTH-1:0] m_x, m_y, bn_eff;
   assign bn_eff = (kind_ff == ralu_pkg::OP_SUB) ? wneg(bn_ff) : bn_ff;
   always_comb begin
      unique case (cmd.mul_sel)
         2'd0: begin m_x = an_ff; m_y = bd_ff; end
         2'd1: begin m_x = bn_eff; m_y = ad_ff; end
         2'd2: begin m_x = ad_ff; m_y = bd_ff; end
         default: begin m_x = an_ff; m_y = bn_ff; end
      endcase
   end

   // One half-width multiplier builds a wrapped product from partial products:
   // low by low, then low by high and high by low shifted up by a half.
   logic [HW-1:0]    m_a, m_b;
   logic [2*HW-1:0]  m_p;
   logic [WIDTH-1:0] m_term, m_sum;
   always_comb begin
      unique case (mph_ff)
         2'd0: begin m_a = m_x[HW-1:0]; m_b = m_y[HW-1:0]; end
         2'd1: begin m_a = m_x[HW-1:0]; m_b = HW'(m_y[WIDTH-1:HW]); end
         default: begin m_a = HW'(m_x[WIDTH-1:HW]); m_b = m_y[HW-1:0]; end
      endcase
   end
   assign m_p = m_a * m_b;
   assign m_term = (mph_ff == 2'd0) ? WIDTH'(m_p) : WIDTH'({m_p, {HW{1'b0}}});
   assign m_sum = macc_ff + m_term;

   // Raw fraction chosen per operation.
   logic [WIDTH-1:0] raw_n, raw_d, neg_n, neg_d;
   logic             fdirect;
   logic [WIDTH-1:0] fn, fd;
   logic [1:0]       ford;
   always_comb begin
      raw_n = '0;
      raw_d = ONE;
      fdirect = 1'b1;
      fn = '0;
      fd = ONE;
      ford = ralu_pkg::ORD_EQ;
      unique case (kind_ff)
         ralu_pkg::OP_MAKE: begin
            raw_n = an_ff; raw_d = ad_ff; fdirect = (ad_ff == '0);
         end
         ralu_pkg::OP_ADD, ralu_pkg::OP_SUB: begin
            raw_n = p_ff[0] + p_ff[1]; raw_d = p_ff[2]; fdirect = 1'b0;
         end
         ralu_pkg::OP_MUL: begin
            raw_n = p_ff[3]; raw_d = p_ff[2]; fdirect = 1'b0;
         end
         ralu_pkg::OP_DIV: begin
            raw_n = p_ff[0]; raw_d = p_ff[1]; fdirect = (bn_ff == '0);
         end
         ralu_pkg::OP_CMP: begin
            fn = an_ff;
            fd = ad_ff;
            if (p_ff[0] == p_ff[1]) ford = ralu_pkg::ORD_EQ;
            else if ($signed(p_ff[0]) < $signed(p_ff[1])) ford = ralu_pkg::ORD_LT;
            else ford = ralu_pkg::ORD_GT;
         end
         default: ;
      endcase
      if (raw_n == '0) fdirect = 1'b1;
      neg_n = raw_d[WIDTH-1] ? wneg(raw_n) : raw_n;
      neg_d = raw_d[WIDTH-1] ? wneg(raw_d) : raw_d;
   end

   // Divider step.
   logic [WIDTH:0]   trial;
   logic [WIDTH-1:0] rem_sh;
   logic             fits;
   assign rem_sh = {drem_ff[WIDTH-2:0], dq_ff[WIDTH-1]};
   assign trial = {drem_ff[WIDTH-1], rem_sh} - {1'b0, ddiv_ff};
   assign fits = !trial[WIDTH];

   // Euclid ends when the remainder operand is zero.
   logic gdone;
   assign gdone = !dbusy_ff && gdiv_ff && (gy_ff == '0);
   assign stat.gcd_done = gdone;
   assign stat.div_done = !dbusy_ff && !gdiv_ff;
   assign stat.direct = fdirect;
   assign stat.mul_done = (mph_ff == 2'd2);

   logic [WIDTH-1:0] dnum;
   always_comb begin
      unique case (cmd.div_mode)
         ralu_pkg::DM_NUM: dnum = mn_ff;
         ralu_pkg::DM_DEN: dnum = md_ff;
         default: dnum = gx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind;
         an_ff <= a_num[WIDTH-1:0];
         ad_ff <= a_den[WIDTH-1:0];
         bn_ff <= b_num[WIDTH-1:0];
         bd_ff <= b_den[WIDTH-1:0];
         mph_ff <= 2'd0;
         dbusy_ff <= 1'b0;
         gdiv_ff <= 1'b0;
      end
      // Accumulate partial products; the last phase stores the wrapped product.
      if (cmd.mul_step) begin
         if (mph_ff == 2'd2) begin
            p_ff[cmd.mul_sel] <= m_sum;
            mph_ff <= 2'd0;
         end else begin
            macc_ff <= (mph_ff == 2'd0) ? m_term : m_sum;
            mph_ff <= mph_ff + 2'd1;
         end
      end
      if (cmd.prep) begin
         rn_ff <= fn;
         rd_ff <= fd;
         ord_ff <= ford;
         n_ff <= neg_n;
         d_ff <= neg_d;
         mn_ff <= mag(neg_n);
         md_ff <= mag(neg_d);
         gx_ff <= mag(neg_n);
         gy_ff <= mag(neg_d);
         gdiv_ff <= 1'b1;
      end
      // Euclid: start x mod y whenever idle and y is nonzero.
      if (gdiv_ff && !dbusy_ff && !cmd.prep && !cmd.load && gy_ff != '0) begin
         dq_ff <= gx_ff;
         drem_ff <= '0;
         ddiv_ff <= gy_ff;
         dcnt_ff <= CW'(WIDTH);
         dbusy_ff <= 1'b1;
      end
      if (cmd.div_start) begin
         gdiv_ff <= 1'b0;
         dq_ff <= dnum;
         drem_ff <= '0;
         ddiv_ff <= gx_ff;
         dcnt_ff <= CW'(WIDTH);
         dbusy_ff <= 1'b1;
      end
      if (dbusy_ff) begin
         drem_ff <= fits ? trial[WIDTH-1:0] : rem_sh;
         dq_ff <= {dq_ff[WIDTH-2:0], fits};
         dcnt_ff <= dcnt_ff - CW'(1);
         if (dcnt_ff == CW'(1)) begin
            dbusy_ff <= 1'b0;
            if (gdiv_ff) begin
               gx_ff <= gy_ff;
               gy_ff <= fits ? trial[WIDTH-1:0] : rem_sh;
            end else if (cmd.div_mode == ralu_pkg::DM_DEN) begin
               md_ff <= {dq_ff[WIDTH-2:0], fits};
            end else begin
               mn_ff <= {dq_ff[WIDTH-2:0], fits};
            end
         end
      end
      // Restore signs after division by the gcd.
      if (cmd.finish) begin
         rn_ff <= n_ff[WIDTH-1] ? wneg(mn_ff) : mn_ff;
         rd_ff <= d_ff[WIDTH-1] ? wneg(md_ff) : md_ff;
         ord_ff <= ralu_pkg::ORD_EQ;
      end
   end

   assign res_num = 64'($signed(rn_ff));
   assign res_den = 64'($signed(rd_ff));
   assign order = ord_ff;

endmodule

// ----- design/rational_alu_core.sv -----
// Top level of the rational ALU.
`timescale 1ns / 1ps
// Fraction ALU: make, add, sub, mul, div and compare on WIDTH-bit numerator and
// denominator pairs, with gcd reduction of every result but compare. One
// transaction is in flight at a time. A transaction first builds the four cross
// products, each from three half-width partial products on one shared
// multiplier, then sets up the reduction; unless the result is trivial, a Euclid
// gcd follows that runs one restoring division per remainder step (up to about
// 1.44*WIDTH steps, typically a few), then two more divisions by the gcd, and
// last the signs are restored; the result is held until it is taken.
module rational_alu_core #(
   parameter int WIDTH = 64
) (
   input  logic clock,
   input  logic reset,
   ralu_if.sink   req,
   ralu_if.source rsp
);

   ralu_pkg::cmd_type  cmd;
   ralu_pkg::stat_type stat;

   ralu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ralu_dpath #(.WIDTH(WIDTH)) u_dpath (
      .clock   (clock),
      .kind    (req.data.kind),
      .a_num   (req.data.a_num),
      .a_den   (req.data.a_den),
      .b_num   (req.data.b_num),
      .b_den   (req.data.b_den),
      .cmd     (cmd),
      .stat    (stat),
      .res_num (rsp.data.res_num),
      .res_den (rsp.data.res_den),
      .order   (rsp.data.order)
   );

endmodule
